// File: src/plb_pkg.sv
package plb_pkg;

    // Vector components: signed Q2.12, unit range -4096..4096 plus headroom
    localparam int VEC_W = 14;
    typedef logic [2:0][VEC_W-1:0] vec3_t;

    localparam int FRAC = 12;
    localparam int INTEN_W = 13;
    localparam int LAM_W = 16;
    localparam int RANGE_W = 16;
    localparam int DIST_W = 16;
    localparam int BRIGHT_W = 13;
    localparam logic [INTEN_W-1:0] ONE_Q12 = 13'd4096;

    // Falloff: 4*pi in Q16, quotient bits of the falloff divider
    localparam logic [19:0] FOURPI_Q16 = 20'd823550;
    localparam int FOURPI_W = 20;
    localparam int FALL_QBITS = 12;
    localparam int ATTEN_PRE = 3;
    localparam int ATTEN_LAT = ATTEN_PRE + FALL_QBITS;

    // Normalizer: reduced component width, root bits, quotient bits
    localparam int NORM_BITS = 20;
    localparam int ROOT_BITS = 21;
    localparam int QUO_BITS = 13;
    localparam int NORM_PRE = 4;
    localparam int NORM_LAT = NORM_PRE + ROOT_BITS + QUO_BITS;

    // Specular term
    localparam int SPEC_W = 16;
    localparam logic [SPEC_W-1:0] SPEC_CAP = 16'hFFFF;
    localparam logic [SPEC_W-1:0] SPEC_FLOOR = 16'd2048;
    localparam int SHADE_FIXED = 6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RANGE = 3'd6;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd10240;

endpackage

// File: src/plb_delay.sv
module plb_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [DEPTH-1:0] load,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Advance each tap when its stage loads
    for (genvar g = 0; g < DEPTH; g++) begin : g_tap
        if (g == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (load[g])
                begin
                    tap_reg[g] <= din;
                end
            end
        end else begin : g_rest
            always_ff @(posedge clk)
            begin
                if (load[g])
                begin
                    tap_reg[g] <= tap_reg[g-1];
                end
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: src/plb_norm.sv
module plb_norm
    import plb_pkg::*;
#(
    parameter int IN_W = 16
) (
    input  logic                      clk,
    input  logic [NORM_LAT-1:0]       load,
    input  logic [2:0][IN_W-1:0]      a,
    input  logic [2:0][IN_W-1:0]      b,
    output vec3_t                     dir_out
);

    localparam int DW = IN_W + 1;
    localparam int MW = (DW > NORM_BITS) ? DW : NORM_BITS;
    localparam int SH_W = $clog2(MW);
    localparam int SQ_W = 2 * NORM_BITS;
    localparam int X_W = 2 * ROOT_BITS;
    localparam int R_W = X_W + 1;
    localparam int REM_W = ROOT_BITS + QUO_BITS - 1;
    localparam int ROOT_BASE = NORM_PRE;
    localparam int DIV_BASE = NORM_PRE + ROOT_BITS;

    // Stage 0: difference vector
    logic signed [DW-1:0] diff_reg [3];

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= DW'($signed(a[i])) - DW'($signed(b[i]));
            end
        end
    end

    // Stage 1: scale down until the largest magnitude fits NORM_BITS
    logic [MW-1:0]   mag [3];
    logic [MW-1:0]   mag_or;
    logic [SH_W-1:0] msb;
    logic [SH_W-1:0] sh;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = MW'($unsigned(diff_reg[i][DW-1] ? -diff_reg[i] : diff_reg[i]));
        end
        mag_or = mag[0] | mag[1] | mag[2];
        msb = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (mag_or[i])
            begin
                msb = SH_W'(i);
            end
        end
        sh = (int'(msb) >= NORM_BITS) ? msb - SH_W'(NORM_BITS - 1) : '0;
    end

    logic [NORM_BITS-1:0] emag1_reg [3];
    logic [2:0]           esign1_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                emag1_reg[i] <= NORM_BITS'(mag[i] >> sh);
                esign1_reg[i] <= diff_reg[i][DW-1];
            end
        end
    end

    // Stage 2: squares
    logic [SQ_W-1:0]      sqr_reg [3];
    logic [NORM_BITS-1:0] emag2_reg [3];
    logic [2:0]           esign2_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sqr_reg[i] <= SQ_W'(emag1_reg[i]) * SQ_W'(emag1_reg[i]);
                emag2_reg[i] <= emag1_reg[i];
            end
            esign2_reg <= esign1_reg;
        end
    end

    // Stage 3: sum of squares
    logic [X_W-1:0]       sum_reg;
    logic [NORM_BITS-1:0] emag3_reg [3];
    logic [2:0]           esign3_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            sum_reg <= X_W'(sqr_reg[0]) + X_W'(sqr_reg[1]) + X_W'(sqr_reg[2]);
            emag3_reg <= emag2_reg;
            esign3_reg <= esign2_reg;
        end
    end

    // Square root: one result bit per stage
    logic [X_W-1:0]       sx_reg [ROOT_BITS];
    logic [R_W-1:0]       sr_reg [ROOT_BITS];
    logic [NORM_BITS-1:0] smag_reg [ROOT_BITS][3];
    logic [2:0]           ssign_reg [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
        localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * (ROOT_BITS - 1 - k));
        logic [X_W-1:0]       x_in;
        logic [R_W-1:0]       r_in;
        logic [R_W-1:0]       trial;
        logic                 ge;
        logic [NORM_BITS-1:0] mag_in [3];
        logic [2:0]           sign_in;

        always_comb
        begin
            if (k == 0)
            begin
                x_in = sum_reg;
                r_in = '0;
                mag_in = emag3_reg;
                sign_in = esign3_reg;
            end
            else
            begin
                x_in = sx_reg[(k == 0) ? 0 : k-1];
                r_in = sr_reg[(k == 0) ? 0 : k-1];
                mag_in = smag_reg[(k == 0) ? 0 : k-1];
                sign_in = ssign_reg[(k == 0) ? 0 : k-1];
            end
            trial = r_in + BIT;
            ge = R_W'(x_in) >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (load[ROOT_BASE + k])
            begin
                sx_reg[k] <= ge ? X_W'(R_W'(x_in) - trial) : x_in;
                sr_reg[k] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
                smag_reg[k] <= mag_in;
                ssign_reg[k] <= sign_in;
            end
        end
    end

    // Division by the length: one quotient bit per stage
    logic [ROOT_BITS-1:0] dlen_reg [QUO_BITS];
    logic [REM_W-1:0]     drem_reg [QUO_BITS][3];
    logic [QUO_BITS-1:0]  dq_reg [QUO_BITS][3];
    logic [2:0]           dsign_reg [QUO_BITS];

    for (genvar d = 0; d < QUO_BITS; d++) begin : g_div
        localparam int B = QUO_BITS - 1 - d;
        logic [ROOT_BITS-1:0] len_in;
        logic [REM_W-1:0]     rem_in [3];
        logic [QUO_BITS-1:0]  q_in [3];
        logic [2:0]           sign_in;
        logic [REM_W-1:0]     trial;

        always_comb
        begin
            if (d == 0)
            begin
                len_in = sr_reg[ROOT_BITS-1][ROOT_BITS-1:0];
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = REM_W'({smag_reg[ROOT_BITS-1][i], FRAC'(0)});
                    q_in[i] = '0;
                end
                sign_in = ssign_reg[ROOT_BITS-1];
            end
            else
            begin
                len_in = dlen_reg[(d == 0) ? 0 : d-1];
                rem_in = drem_reg[(d == 0) ? 0 : d-1];
                q_in = dq_reg[(d == 0) ? 0 : d-1];
                sign_in = dsign_reg[(d == 0) ? 0 : d-1];
            end
            trial = REM_W'(len_in) << B;
        end

        always_ff @(posedge clk)
        begin
            if (load[DIV_BASE + d])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_in[i] >= trial)
                    begin
                        drem_reg[d][i] <= rem_in[i] - trial;
                        dq_reg[d][i] <= q_in[i] | (QUO_BITS'(1) << B);
                    end
                    else
                    begin
                        drem_reg[d][i] <= rem_in[i];
                        dq_reg[d][i] <= q_in[i];
                    end
                end
                dlen_reg[d] <= len_in;
                dsign_reg[d] <= sign_in;
            end
        end
    end

    // Apply sign; a zero-length vector gives the zero vector
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dlen_reg[QUO_BITS-1] == '0)
            begin
                dir_out[i] = '0;
            end
            else if (dsign_reg[QUO_BITS-1][i])
            begin
                dir_out[i] = -VEC_W'(dq_reg[QUO_BITS-1][i]);
            end
            else
            begin
                dir_out[i] = VEC_W'(dq_reg[QUO_BITS-1][i]);
            end
        end
    end

endmodule

// File: src/plb_atten.sv
module plb_atten
    import plb_pkg::*;
(
    input  logic                 clk,
    input  logic [ATTEN_LAT-1:0] load,
    input  logic [RANGE_W-1:0]   light_range,
    input  logic [DIST_W-1:0]    dist_sq,
    input  vec3_t                normal,
    input  vec3_t                light_dir,
    output logic [INTEN_W-1:0]   inten,
    output logic [LAM_W-1:0]     lam
);

    localparam int RSQ_W = 2 * RANGE_W;
    localparam int DSQ_W = 2 * DIST_W;
    localparam int NUM_SHIFT = 16 + FRAC;
    localparam int NUM_W = RSQ_W + NUM_SHIFT;
    localparam int DEN_W = FOURPI_W + DSQ_W;
    localparam int DIV_W = DEN_W + FRAC;
    localparam int LP_W = 2 * VEC_W;
    localparam int ACC_W = LP_W + 2;

    // Stage 0: squares and Lambert products
    logic [RSQ_W-1:0]       rsq_reg;
    logic [DSQ_W-1:0]       dsq_reg;
    logic signed [LP_W-1:0] lp_reg [3];

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            rsq_reg <= RSQ_W'(light_range) * RSQ_W'(light_range);
            dsq_reg <= DSQ_W'(dist_sq) * DSQ_W'(dist_sq);
            for (int i = 0; i < 3; i++)
            begin
                lp_reg[i] <= LP_W'($signed(normal[i])) * LP_W'($signed(light_dir[i]));
            end
        end
    end

    // Stage 1: numerator, denominator, clamped Lambert term
    logic signed [ACC_W-1:0] acc;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [LAM_W-1:0]        lam1_reg;

    assign acc = ACC_W'(lp_reg[0]) + ACC_W'(lp_reg[1]) + ACC_W'(lp_reg[2]);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            num_reg <= {rsq_reg, NUM_SHIFT'(0)};
            den_reg <= DEN_W'(FOURPI_Q16) * DEN_W'(dsq_reg);
            lam1_reg <= (acc > 0) ? acc[FRAC +: LAM_W] : '0;
        end
    end

    // Stage 2: saturation test, zero distance lands here too
    logic [DIV_W-1:0] rem2_reg;
    logic [DEN_W-1:0] den2_reg;
    logic             sat2_reg;
    logic [LAM_W-1:0] lam2_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            rem2_reg <= DIV_W'(num_reg);
            den2_reg <= den_reg;
            sat2_reg <= DIV_W'(num_reg) >= {den_reg, FRAC'(0)};
            lam2_reg <= lam1_reg;
        end
    end

    // Divider: one quotient bit per stage
    logic [DIV_W-1:0]      frem_reg [FALL_QBITS];
    logic [DEN_W-1:0]      fden_reg [FALL_QBITS];
    logic [FALL_QBITS-1:0] fq_reg [FALL_QBITS];
    logic                  fsat_reg [FALL_QBITS];
    logic [LAM_W-1:0]      flam_reg [FALL_QBITS];

    for (genvar d = 0; d < FALL_QBITS; d++) begin : g_div
        localparam int B = FALL_QBITS - 1 - d;
        logic [DIV_W-1:0]      rem_in;
        logic [DEN_W-1:0]      den_in;
        logic [FALL_QBITS-1:0] q_in;
        logic                  sat_in;
        logic [LAM_W-1:0]      lam_in;
        logic [DIV_W-1:0]      trial;

        always_comb
        begin
            if (d == 0)
            begin
                rem_in = rem2_reg;
                den_in = den2_reg;
                q_in = '0;
                sat_in = sat2_reg;
                lam_in = lam2_reg;
            end
            else
            begin
                rem_in = frem_reg[(d == 0) ? 0 : d-1];
                den_in = fden_reg[(d == 0) ? 0 : d-1];
                q_in = fq_reg[(d == 0) ? 0 : d-1];
                sat_in = fsat_reg[(d == 0) ? 0 : d-1];
                lam_in = flam_reg[(d == 0) ? 0 : d-1];
            end
            trial = DIV_W'(den_in) << B;
        end

        always_ff @(posedge clk)
        begin
            if (load[ATTEN_PRE + d])
            begin
                if (rem_in >= trial)
                begin
                    frem_reg[d] <= rem_in - trial;
                    fq_reg[d] <= q_in | (FALL_QBITS'(1) << B);
                end
                else
                begin
                    frem_reg[d] <= rem_in;
                    fq_reg[d] <= q_in;
                end
                fden_reg[d] <= den_in;
                fsat_reg[d] <= sat_in;
                flam_reg[d] <= lam_in;
            end
        end
    end

    // Clamp falloff to one
    assign inten = fsat_reg[FALL_QBITS-1] ? ONE_Q12 : INTEN_W'(fq_reg[FALL_QBITS-1]);
    assign lam = flam_reg[FALL_QBITS-1];

endmodule

// File: src/plb_shade.sv
module plb_shade
    import plb_pkg::*;
#(
    parameter int SQUARINGS = 8
) (
    input  logic                            clk,
    input  logic [SQUARINGS+SHADE_FIXED-1:0] load,
    input  vec3_t                           view,
    input  vec3_t                           inc,
    input  vec3_t                           normal,
    input  logic [INTEN_W-1:0]              inten,
    input  logic [LAM_W-1:0]                lam,
    output logic [BRIGHT_W-1:0]             brightness
);

    localparam int IP_W = 2 * VEC_W;
    localparam int IS_W = IP_W + 2;
    localparam int K_W = IS_W - FRAC;
    localparam int T_W = VEC_W + K_W + 2;
    localparam int R_W = T_W - FRAC + 1;
    localparam int VR_W = VEC_W + R_W;
    localparam int VS_W = VR_W + 2;
    localparam int LI_W = INTEN_W + LAM_W;
    localparam int SQP_W = 2 * SPEC_W;
    localparam int SQS_W = SQP_W - FRAC;
    localparam int P_W = LI_W + SPEC_W;
    localparam int B_W = P_W - 24;
    localparam int FINAL = SQUARINGS + SHADE_FIXED - 1;

    // Stage 0: incidence dot normal, falloff times Lambert
    logic signed [IP_W-1:0] ip_reg [3];
    vec3_t                  v0_reg, inc0_reg, n0_reg;
    logic [LI_W-1:0]        li0_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ip_reg[i] <= IP_W'($signed(inc[i])) * IP_W'($signed(normal[i]));
            end
            v0_reg <= view;
            inc0_reg <= inc;
            n0_reg <= normal;
            li0_reg <= LI_W'(inten) * LI_W'(lam);
        end
    end

    // Stage 1: k = floor(Inc.N / 4096)
    logic signed [IS_W-1:0] isum;
    logic signed [K_W-1:0]  k_reg;
    vec3_t                  v1_reg, inc1_reg, n1_reg;
    logic [LI_W-1:0]        li1_reg;

    assign isum = IS_W'(ip_reg[0]) + IS_W'(ip_reg[1]) + IS_W'(ip_reg[2]);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            k_reg <= K_W'(isum >>> FRAC);
            v1_reg <= v0_reg;
            inc1_reg <= inc0_reg;
            n1_reg <= n0_reg;
            li1_reg <= li0_reg;
        end
    end

    // Stage 2: reflect the incidence vector about the normal
    logic signed [T_W-1:0] t [3];
    logic signed [R_W-1:0] r_reg [3];
    vec3_t                 v2_reg;
    logic [LI_W-1:0]       li2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t[i] = ((T_W'($signed(n1_reg[i])) * T_W'(k_reg)) <<< 1) >>> FRAC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= R_W'($signed(inc1_reg[i])) - R_W'(t[i]);
            end
            v2_reg <= v1_reg;
            li2_reg <= li1_reg;
        end
    end

    // Stage 3: view times reflection
    logic signed [VR_W-1:0] vr_reg [3];
    logic [LI_W-1:0]        li3_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                vr_reg[i] <= VR_W'($signed(v2_reg[i])) * VR_W'(r_reg[i]);
            end
            li3_reg <= li2_reg;
        end
    end

    // Stage 4: magnitude of V.R, saturated
    logic signed [VS_W-1:0] vs;
    logic [VS_W-1:0]        vs_mag;
    logic [SPEC_W-1:0]      spec4_reg;
    logic [LI_W-1:0]        li4_reg;

    always_comb
    begin
        vs = (VS_W'(vr_reg[0]) + VS_W'(vr_reg[1]) + VS_W'(vr_reg[2])) >>> FRAC;
        vs_mag = $unsigned(vs[VS_W-1] ? -vs : vs);
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            spec4_reg <= (vs_mag > VS_W'(SPEC_CAP)) ? SPEC_CAP : SPEC_W'(vs_mag);
            li4_reg <= li3_reg;
        end
    end

    // Squarings: one per stage, each saturated
    logic [SPEC_W-1:0] sp_reg [SQUARINGS];
    logic [LI_W-1:0]   lis_reg [SQUARINGS];

    for (genvar g = 0; g < SQUARINGS; g++) begin : g_sq
        logic [SPEC_W-1:0] s_in;
        logic [LI_W-1:0]   li_in;
        logic [SQP_W-1:0]  p;
        logic [SQS_W-1:0]  ps;

        always_comb
        begin
            if (g == 0)
            begin
                s_in = spec4_reg;
                li_in = li4_reg;
            end
            else
            begin
                s_in = sp_reg[(g == 0) ? 0 : g-1];
                li_in = lis_reg[(g == 0) ? 0 : g-1];
            end
            p = SQP_W'(s_in) * SQP_W'(s_in);
            ps = SQS_W'(p >> FRAC);
        end

        always_ff @(posedge clk)
        begin
            if (load[5 + g])
            begin
                sp_reg[g] <= (ps > SQS_W'(SPEC_CAP)) ? SPEC_CAP : SPEC_W'(ps);
                lis_reg[g] <= li_in;
            end
        end
    end

    // Final: floor the specular term, take the product and clamp to one
    logic [SPEC_W-1:0]   spec_f;
    logic [P_W-1:0]      prod;
    logic [B_W-1:0]      bval;
    logic [BRIGHT_W-1:0] bright_reg;

    always_comb
    begin
        spec_f = (sp_reg[SQUARINGS-1] < SPEC_FLOOR) ? SPEC_FLOOR : sp_reg[SQUARINGS-1];
        prod = P_W'(lis_reg[SQUARINGS-1]) * P_W'(spec_f);
        bval = B_W'(prod >> 24);
    end

    always_ff @(posedge clk)
    begin
        if (load[FINAL])
        begin
            bright_reg <= (bval > B_W'(ONE_Q12)) ? ONE_Q12 : BRIGHT_W'(bval);
        end
    end

    assign brightness = bright_reg;

endmodule

// File: src/point_light_brightness_core.sv
// Point light brightness, one shaded point per beat.
// Input channel (in_valid/in_ready): surface point, unit normal, unit
// direction to the light and squared light distance. Output channel
// (out_valid/out_ready): brightness in Q0.12, 4096 meaning full brightness.
// Camera, light position and light range are set through the write port
// (wr_en, wr_index, wr_data); the user must write them only while no beat
// is in flight, as the block itself does not enforce this.
// Pipeline: 4 setup stages, 21 square-root stages and 13 divide stages in
// the two vector normalizers, then 6 + SPECULAR_SQUARINGS shading stages.
// The falloff divider and the Lambert term run beside the normalizers.
// Throughput: one beat per cycle while in_ready is high; every stage is
// registered and carries its own valid bit.
// Stall: when out_ready is low the last stage holds; earlier stages keep
// filling empty slots, so in_ready drops only once every stage is full.
// Nothing is lost or repeated.
// Reset: all valid bits clear, camera and light go to the origin, light
// range goes to 2.5.
module point_light_brightness_core
    import plb_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int SPECULAR_SQUARINGS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [CFG_IDX_W-1:0]          wr_index,
    input  logic [((COORD_WIDTH > RANGE_W) ? COORD_WIDTH : RANGE_W)-1:0] wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [VEC_W-1:0]       normal_x,
    input  logic signed [VEC_W-1:0]       normal_y,
    input  logic signed [VEC_W-1:0]       normal_z,
    input  logic signed [VEC_W-1:0]       light_dir_x,
    input  logic signed [VEC_W-1:0]       light_dir_y,
    input  logic signed [VEC_W-1:0]       light_dir_z,
    input  logic [DIST_W-1:0]             dist_sq,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [BRIGHT_W-1:0]           brightness
);

    localparam int DEPTH = NORM_LAT + SPECULAR_SQUARINGS + SHADE_FIXED;

    // Configuration registers
    logic [COORD_WIDTH-1:0] camera_x_reg, camera_y_reg, camera_z_reg;
    logic [COORD_WIDTH-1:0] light_x_reg, light_y_reg, light_z_reg;
    logic [RANGE_W-1:0]     range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg <= '0;
            camera_y_reg <= '0;
            camera_z_reg <= '0;
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
            range_reg <= RANGE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CAMERA_X:    camera_x_reg <= wr_data[COORD_WIDTH-1:0];
                REG_CAMERA_Y:    camera_y_reg <= wr_data[COORD_WIDTH-1:0];
                REG_CAMERA_Z:    camera_z_reg <= wr_data[COORD_WIDTH-1:0];
                REG_LIGHT_X:     light_x_reg <= wr_data[COORD_WIDTH-1:0];
                REG_LIGHT_Y:     light_y_reg <= wr_data[COORD_WIDTH-1:0];
                REG_LIGHT_Z:     light_z_reg <= wr_data[COORD_WIDTH-1:0];
                REG_LIGHT_RANGE: range_reg <= wr_data[RANGE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Pipeline control: a stage loads when out_ready is high or when it or any later stage is empty
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] load;
    logic [DEPTH-1:0] valid_prev;

    for (genvar g = 0; g < DEPTH; g++) begin : g_load
        assign load[g] = out_ready | ~(&valid_reg[DEPTH-1:g]);
    end

    assign valid_prev = {valid_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_prev[i];
                end
            end
        end
    end

    assign in_ready = load[0];
    assign out_valid = valid_reg[DEPTH-1];

    // View and incidence directions
    vec3_t view_dir, inc_dir;

    plb_norm #(
        .IN_W(COORD_WIDTH)
    ) u_view (
        .clk    (clk),
        .load   (load[NORM_LAT-1:0]),
        .a      ({camera_z_reg, camera_y_reg, camera_x_reg}),
        .b      ({point_z, point_y, point_x}),
        .dir_out(view_dir)
    );

    plb_norm #(
        .IN_W(COORD_WIDTH)
    ) u_inc (
        .clk    (clk),
        .load   (load[NORM_LAT-1:0]),
        .a      ({point_z, point_y, point_x}),
        .b      ({light_z_reg, light_y_reg, light_x_reg}),
        .dir_out(inc_dir)
    );

    // Falloff and Lambert term
    logic [INTEN_W-1:0] inten, inten_dly;
    logic [LAM_W-1:0]   lam, lam_dly;

    plb_atten u_atten (
        .clk        (clk),
        .load       (load[ATTEN_LAT-1:0]),
        .light_range(range_reg),
        .dist_sq    (dist_sq),
        .normal     ({normal_z, normal_y, normal_x}),
        .light_dir  ({light_dir_z, light_dir_y, light_dir_x}),
        .inten      (inten),
        .lam        (lam)
    );

    // Align side data with the normalizer outputs
    vec3_t normal_dly;

    plb_delay #(
        .WIDTH(3 * VEC_W),
        .DEPTH(NORM_LAT)
    ) u_normal_dly (
        .clk (clk),
        .load(load[NORM_LAT-1:0]),
        .din ({normal_z, normal_y, normal_x}),
        .dout(normal_dly)
    );

    plb_delay #(
        .WIDTH(INTEN_W + LAM_W),
        .DEPTH(NORM_LAT - ATTEN_LAT)
    ) u_atten_dly (
        .clk (clk),
        .load(load[NORM_LAT-1:ATTEN_LAT]),
        .din ({inten, lam}),
        .dout({inten_dly, lam_dly})
    );

    // Reflection, specular power and final product
    plb_shade #(
        .SQUARINGS(SPECULAR_SQUARINGS)
    ) u_shade (
        .clk       (clk),
        .load      (load[DEPTH-1:NORM_LAT]),
        .view      (view_dir),
        .inc       (inc_dir),
        .normal    (normal_dly),
        .inten     (inten_dly),
        .lam       (lam_dly),
        .brightness(brightness)
    );

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plb_pkg::*;

    localparam int CW = 16;
    localparam int LATENCY = 52;
    localparam longint CYCLE_LIMIT = 2000000;

    // Scoreboard: predicts brightness per accepted point, checks results in order
    class brightness_board;
        logic signed [CW-1:0] camera [3];
        logic signed [CW-1:0] light [3];
        logic [RANGE_W-1:0] range_q12;
        logic [BRIGHT_W-1:0] pending [$];
        int errors;

        function new();
            errors = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            for (int i = 0; i < 3; i++)
            begin
                camera[i] = '0;
                light[i] = '0;
            end
            range_q12 = RANGE_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_CAMERA_X: camera[0] = val;
                REG_CAMERA_Y: camera[1] = val;
                REG_CAMERA_Z: camera[2] = val;
                REG_LIGHT_X: light[0] = val;
                REG_LIGHT_Y: light[1] = val;
                REG_LIGHT_Z: light[2] = val;
                REG_LIGHT_RANGE: range_q12 = val;
                default: ;
            endcase
        endfunction

        // Floor division by 2^s for signed values
        function longint fshr(longint x, int s);
            return x >>> s;
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // Reduce below 2^20, then scale each component to unit length in Q12
        function void unit_vec(input longint d[3], output longint o[3]);
            longint unsigned m;
            longint unsigned sum;
            longint unsigned len;
            longint e[3];
            longint a;
            int sh;
            m = 0;
            sum = 0;
            sh = 0;
            for (int i = 0; i < 3; i++)
            begin
                a = d[i] < 0 ? -d[i] : d[i];
                if (a > m)
                    m = a;
            end
            while ((m >> sh) >= (64'd1 << 20))
                sh++;
            for (int i = 0; i < 3; i++)
            begin
                e[i] = d[i] >= 0 ? (d[i] >>> sh) : -((-d[i]) >>> sh);
                sum += e[i] * e[i];
            end
            len = isqrt(sum);
            for (int i = 0; i < 3; i++)
                o[i] = (len == 0) ? 0 : (e[i] * 4096) / longint'(len);
        endfunction

        function void note_point(logic signed [CW-1:0] p[3], logic signed [VEC_W-1:0] n[3],
                                 logic signed [VEC_W-1:0] l[3], logic [DIST_W-1:0] d);
            longint vd[3], id[3], v[3], inc[3], r[3];
            longint acc, k, s;
            longint unsigned inten, lam, spec, b, num, den, rng;
            rng = range_q12;
            for (int i = 0; i < 3; i++)
            begin
                vd[i] = longint'(camera[i]) - longint'(p[i]);
                id[i] = longint'(p[i]) - longint'(light[i]);
            end
            // falloff
            if (d == 0)
                inten = 4096;
            else
            begin
                num = (rng * rng) << 28;
                den = 64'd823550 * d * d;
                inten = (num >= den * 4096) ? 4096 : num / den;
            end
            // Lambert
            acc = longint'(n[0]) * l[0] + longint'(n[1]) * l[1] + longint'(n[2]) * l[2];
            lam = acc > 0 ? (acc >>> 12) : 0;
            // specular
            unit_vec(vd, v);
            unit_vec(id, inc);
            k = fshr(inc[0] * n[0] + inc[1] * n[1] + inc[2] * n[2], 12);
            for (int i = 0; i < 3; i++)
                r[i] = inc[i] - fshr(2 * longint'(n[i]) * k, 12);
            s = fshr(v[0] * r[0] + v[1] * r[1] + v[2] * r[2], 12);
            spec = s < 0 ? -s : s;
            if (spec > 65535)
                spec = 65535;
            for (int i = 0; i < 8; i++)
            begin
                spec = (spec * spec) >> 12;
                if (spec > 65535)
                    spec = 65535;
            end
            if (spec < 2048)
                spec = 2048;
            b = (inten * lam * spec) >> 24;
            if (b > 4096)
                b = 4096;
            pending.push_back(b[BRIGHT_W-1:0]);
        endfunction

        function void check_result(logic [BRIGHT_W-1:0] got);
            logic [BRIGHT_W-1:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected brightness beat, expected none, actual %0d",
                         $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: brightness mismatch, expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic wr_en = 0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [15:0] wr_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
    logic signed [VEC_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic signed [VEC_W-1:0] light_dir_x = '0, light_dir_y = '0, light_dir_z = '0;
    logic [DIST_W-1:0] dist_sq = '0;
    logic out_valid;
    logic out_ready = 0;
    logic [BRIGHT_W-1:0] brightness;

    brightness_board board = new();
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    longint cycles;

    point_light_brightness_core uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Sample accepted beats on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_point('{point_x, point_y, point_z},
                             '{normal_x, normal_y, normal_z},
                             '{light_dir_x, light_dir_y, light_dir_z}, dist_sq);
        if (rst_n && out_valid && out_ready)
            board.check_result(brightness);
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        wr_en <= 1;
        wr_index <= idx;
        wr_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        wr_en <= 0;
    endtask

    // Offer one point and hold it until accepted; leaves valid high on return
    task automatic send_point(logic signed [CW-1:0] px, py, pz,
                              logic signed [VEC_W-1:0] nx, ny, nz, lx, ly, lz,
                              logic [DIST_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        point_x <= px; point_y <= py; point_z <= pz;
        normal_x <= nx; normal_y <= ny; normal_z <= nz;
        light_dir_x <= lx; light_dir_y <= ly; light_dir_z <= lz;
        dist_sq <= d;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drain: wait for every expected beat, then the pipeline latency
    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    function automatic logic signed [VEC_W-1:0] rand_unit();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return VEC_W'($urandom);
        return VEC_W'($signed($urandom_range(8192)) - 4096);
    endfunction

    // Mostly components within the unit range, some arbitrary 14-bit values
    task automatic send_random();
        logic [DIST_W-1:0] d;
        int r;
        r = $urandom_range(9);
        d = (r == 0) ? 16'd0 : (r < 4) ? DIST_W'($urandom) : DIST_W'($urandom_range(8192, 1));
        send_point(CW'($urandom), CW'($urandom), CW'($urandom),
                   rand_unit(), rand_unit(), rand_unit(),
                   rand_unit(), rand_unit(), rand_unit(), d);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_random();
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: extremes and the named special cases at reset settings
        send_point(0, 0, 0, 0, 0, 4096, 0, 0, 4096, 0);
        send_point(4096, 0, 0, 0, 0, 4096, 0, 0, 4096, 4096);
        send_point(-32768, -32768, -32768, -4096, -4096, -4096, 4096, 4096, 4096, 65535);
        send_point(32767, 32767, 32767, 4096, 0, 0, 4096, 0, 0, 1);
        send_point(-32768, 32767, 0, -8192, 8191, 0, -8192, 8191, 0, 100);
        send_point(8191, -8192, 100, 0, 4096, 0, 0, -4096, 0, 16);
        send_point(2896, 2896, 0, 2896, 2896, 0, 2896, 2896, 0, 2048);
        drain();

        // Zero range, camera and light at opposite ends of x, extreme positions
        write_cfg(REG_LIGHT_RANGE, 0);
        write_cfg(REG_CAMERA_X, 16'h7FFF);
        write_cfg(REG_LIGHT_X, 16'h8000);
        send_point(0, 0, 0, 0, 0, 4096, 0, 0, 4096, 0);
        send_point(0, 0, 0, 0, 0, 4096, 0, 0, 4096, 500);
        send_point(-32768, 0, 0, 4096, 0, 0, 4096, 0, 0, 300);
        send_point(32767, 0, 0, 4096, 0, 0, -4096, 0, 0, 300);
        drain();
        write_cfg(REG_LIGHT_RANGE, 16'hFFFF);
        write_cfg(REG_CAMERA_Y, 16'h1000);
        write_cfg(REG_CAMERA_Z, 16'h8000);
        write_cfg(REG_LIGHT_Y, 16'h7FFF);
        write_cfg(REG_LIGHT_Z, 16'h2000);
        send_point(0, 4096, -32768, 0, 4096, 0, 0, 4096, 0, 1);
        send_point(0, 0, 0, 0, 0, 4096, 0, 0, 4096, 65535);
        drain();

        // Random phases with various settings and idling profiles
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 58 : 0;
            recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 14 : 0;
            for (int i = 0; i < 7; i++)
                write_cfg(i[CFG_IDX_W-1:0],
                          (i == 6) ? 16'($urandom_range(65535, 1)) : 16'($urandom));
            if (ph == 5)
            begin
                // Long receiver hold-off while points keep coming
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                    random_phase(150);
                join
            end
            random_phase(320);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: sim.f
src/plb_pkg.sv
src/plb_delay.sv
src/plb_norm.sv
src/plb_atten.sv
src/plb_shade.sv
src/point_light_brightness_core.sv
test/tb_top.sv
